### src/wsa_pkg.sv
// Shared constants, lookup tables and types for the window surface area core.
// No dependencies; every other file but wsa_isqrt imports this package.
package wsa_pkg;

    localparam int CELLS    = 9;
    localparam int EDGES    = 16;
    localparam int TRIS     = 8;
    localparam int ELEV_W   = 32;
    localparam int SIZE_W   = 32;
    localparam int SQ_W     = 64;
    localparam int SPAN_W   = 66;
    localparam int HALF_W   = 32;
    localparam int RADIC_W  = 100;
    localparam int TAREA_W  = RADIC_W / 2;
    localparam int SUM_W    = TAREA_W + 3;
    localparam int DIV_W    = SUM_W + 3;
    localparam int CNT_W    = 4;
    localparam int AREA_W   = 63;
    localparam int CFG_A_W  = 2;

    localparam int EDGE_LAT = 3 + SPAN_W / 2;
    localparam int TRI_LAT  = 4 + RADIC_W / 2;
    localparam int MERGE_LAT = 3 + DIV_W;

    localparam logic [CFG_A_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_DROP   = 2'd2;

    localparam logic [1:0] SPAN_X = 2'd0;
    localparam logic [1:0] SPAN_Y = 2'd1;
    localparam logic [1:0] SPAN_D = 2'd2;

    typedef logic [3:0] t_cell_idx;
    typedef logic [3:0] t_edge_idx;

    // Edges: ab bc de ef gh hi, ad dg be eh cf fi, ea ec eg ei.
    localparam t_cell_idx EDGE_P [EDGES] = '{
        4'd0, 4'd1, 4'd3, 4'd4, 4'd6, 4'd7,
        4'd0, 4'd3, 4'd1, 4'd4, 4'd2, 4'd5,
        4'd4, 4'd4, 4'd4, 4'd4};
    localparam t_cell_idx EDGE_Q [EDGES] = '{
        4'd1, 4'd2, 4'd4, 4'd5, 4'd7, 4'd8,
        4'd3, 4'd6, 4'd4, 4'd7, 4'd5, 4'd8,
        4'd0, 4'd2, 4'd6, 4'd8};
    localparam logic [1:0] EDGE_SPAN [EDGES] = '{
        SPAN_X, SPAN_X, SPAN_X, SPAN_X, SPAN_X, SPAN_X,
        SPAN_Y, SPAN_Y, SPAN_Y, SPAN_Y, SPAN_Y, SPAN_Y,
        SPAN_D, SPAN_D, SPAN_D, SPAN_D};

    localparam t_edge_idx TRI_SIDE [TRIS][3] = '{
        '{4'd12, 4'd0,  4'd8},
        '{4'd8,  4'd1,  4'd13},
        '{4'd6,  4'd2,  4'd12},
        '{4'd13, 4'd10, 4'd3},
        '{4'd2,  4'd7,  4'd14},
        '{4'd3,  4'd11, 4'd15},
        '{4'd14, 4'd9,  4'd4},
        '{4'd9,  4'd15, 4'd5}};

    localparam logic [CELLS-1:0] TRI_MASK [TRIS] = '{
        9'h013, 9'h016, 9'h019, 9'h034, 9'h058, 9'h130, 9'h0D0, 9'h190};

    typedef struct packed {
        logic            vld;
        logic            last;
        logic            drop;
        logic            full;
        logic [TRIS-1:0] keep;
    } t_info;

endpackage

### src/window_surface_area_core.sv
// Top level of the window surface area core: configuration registers, input
// staging, 16 half-edge lanes, 8 triangle lanes and the merge stage.
// Depends on wsa_pkg, wsa_edge, wsa_tri and wsa_merge.
//
// The core accepts one 3x3 window on every clock cycle and busy is always low.
// Each window yields exactly one result transaction, shown for one cycle on
// o_done; results come out in input order and must be taken when shown. The
// latency is set by the 33-step square root of the half-edge lanes, the 50-step
// square root of the triangle lanes and the 56-step divider that rescales the
// sum in drop-missing mode. Configuration writes are expected only while no
// transaction is in flight.
module window_surface_area_core
    import wsa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_A_W-1:0]       i_cfg_addr,
    input  logic [SIZE_W-1:0]        i_cfg_wdata,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [ELEV_W-1:0] i_elev_a,
    input  logic signed [ELEV_W-1:0] i_elev_b,
    input  logic signed [ELEV_W-1:0] i_elev_c,
    input  logic signed [ELEV_W-1:0] i_elev_d,
    input  logic signed [ELEV_W-1:0] i_elev_e,
    input  logic signed [ELEV_W-1:0] i_elev_f,
    input  logic signed [ELEV_W-1:0] i_elev_g,
    input  logic signed [ELEV_W-1:0] i_elev_h,
    input  logic signed [ELEV_W-1:0] i_elev_i,
    input  logic [CELLS-1:0]         i_valid_mask,
    input  logic                     i_last_window,
    output logic                     o_done,
    output logic [AREA_W-1:0]        o_area,
    output logic                     o_area_valid,
    output logic                     o_window_last
);

    localparam int DLY     = EDGE_LAT + TRI_LAT;
    localparam int LATENCY = 2 + DLY + MERGE_LAT;

    logic [SIZE_W-1:0] r_size_x;
    logic [SIZE_W-1:0] r_size_y;
    logic              r_drop;

    logic signed [ELEV_W-1:0] w_z   [CELLS];
    logic signed [ELEV_W-1:0] r_a_z [CELLS];
    logic signed [ELEV_W-1:0] r_b_z [CELLS];
    t_info                    n_info;
    t_info                    r_a_info;
    t_info                    r_b_info;
    t_info                    r_dly [DLY];
    logic [SQ_W-1:0]          r_a_sx, r_a_sy;
    logic [SPAN_W-1:0]        r_b_sx, r_b_sy, r_b_sd;

    logic [HALF_W-1:0]  w_half [EDGES];
    logic [TAREA_W-1:0] w_tarea [TRIS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_W'(65536);
            r_size_y <= SIZE_W'(65536);
            r_drop   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SIZE_X: r_size_x <= i_cfg_wdata;
                CFG_SIZE_Y: r_size_y <= i_cfg_wdata;
                CFG_DROP:   r_drop   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    assign w_z = '{i_elev_a, i_elev_b, i_elev_c, i_elev_d, i_elev_e,
                   i_elev_f, i_elev_g, i_elev_h, i_elev_i};

    always_comb begin
        n_info.vld  = start & ~busy;
        n_info.last = i_last_window;
        n_info.drop = r_drop;
        n_info.full = &i_valid_mask;
        for (int k = 0; k < TRIS; k++) begin
            n_info.keep[k] = ((i_valid_mask & TRI_MASK[k]) == TRI_MASK[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_z  <= w_z;
        r_a_sx <= r_size_x * r_size_x;
        r_a_sy <= r_size_y * r_size_y;
        r_b_z  <= r_a_z;
        r_b_sx <= {2'b00, r_a_sx};
        r_b_sy <= {2'b00, r_a_sy};
        r_b_sd <= {2'b00, r_a_sx} + {2'b00, r_a_sy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_info <= '0;
            r_b_info <= '0;
            for (int k = 0; k < DLY; k++) begin
                r_dly[k] <= '0;
            end
        end else begin
            r_a_info <= n_info;
            r_b_info <= r_a_info;
            r_dly[0] <= r_b_info;
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    genvar e, t;
    for (e = 0; e < EDGES; e++) begin : g_edge
        logic [SPAN_W-1:0] span;
        if (EDGE_SPAN[e] == SPAN_X) begin : g_x
            assign span = r_b_sx;
        end else if (EDGE_SPAN[e] == SPAN_Y) begin : g_y
            assign span = r_b_sy;
        end else begin : g_d
            assign span = r_b_sd;
        end

        wsa_edge u_edge (
            .i_clk  (i_clk),
            .i_span (span),
            .i_z1   (r_b_z[EDGE_P[e]]),
            .i_z2   (r_b_z[EDGE_Q[e]]),
            .o_half (w_half[e])
        );
    end

    for (t = 0; t < TRIS; t++) begin : g_tri
        wsa_tri u_tri (
            .i_clk  (i_clk),
            .i_a    (w_half[TRI_SIDE[t][0]]),
            .i_b    (w_half[TRI_SIDE[t][1]]),
            .i_c    (w_half[TRI_SIDE[t][2]]),
            .o_area (w_tarea[t])
        );
    end

    wsa_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_info        (r_dly[DLY-1]),
        .i_area        (w_tarea),
        .o_done        (o_done),
        .o_area        (o_area),
        .o_area_valid  (o_area_valid),
        .o_window_last (o_window_last)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("result transaction missing at fixed latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LATENCY))
        else $error("result transaction without a matching start");

    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_window_last == $past(i_last_window, LATENCY)))
        else $error("window_last does not follow its window");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_area_valid) |-> (o_area == '0))
        else $error("invalid result carries a nonzero area");

endmodule

### src/wsa_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Uses no package items; instantiated by wsa_edge and wsa_tri.
module wsa_isqrt #(
    parameter int IN_W = 66
) (
    input  logic                i_clk,
    input  logic [IN_W-1:0]     i_x,
    output logic [IN_W/2-1:0]   o_root
);

    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 3;

    logic [IN_W-1:0]  r_x    [1:OUT_W-1];
    logic [RW-1:0]    r_rem  [1:OUT_W-1];
    logic [OUT_W-1:0] r_root [1:OUT_W];

    genvar s;
    for (s = 0; s < OUT_W; s++) begin : g_step
        logic [IN_W-1:0]  x_in;
        logic [RW-1:0]    rem_in;
        logic [RW-1:0]    rem_sh;
        logic [RW-1:0]    trial;
        logic [RW-1:0]    rem_nx;
        logic [OUT_W-1:0] root_in;
        logic             take;

        if (s == 0) begin : g_first
            assign x_in    = i_x;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = r_x[s];
            assign rem_in  = r_rem[s];
            assign root_in = r_root[s];
        end

        assign rem_sh = {rem_in[RW-3:0], x_in[IN_W-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign take   = (rem_sh >= trial);
        assign rem_nx = take ? (rem_sh - trial) : rem_sh;

        always_ff @(posedge i_clk) begin
            r_root[s+1] <= {root_in[OUT_W-2:0], take};
        end

        if (s < OUT_W - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                r_x[s+1]   <= {x_in[IN_W-3:0], 2'b00};
                r_rem[s+1] <= rem_nx;
            end
        end
    end

    assign o_root = r_root[OUT_W];

endmodule

### src/wsa_edge.sv
// Half-edge lane: floor(isqrt(span + dz^2) / 2) for one edge; span is already squared.
// Depends on wsa_pkg and wsa_isqrt.
module wsa_edge
    import wsa_pkg::*;
(
    input  logic                     i_clk,
    input  logic [SPAN_W-1:0]        i_span,
    input  logic signed [ELEV_W-1:0] i_z1,
    input  logic signed [ELEV_W-1:0] i_z2,
    output logic [HALF_W-1:0]        o_half
);

    logic signed [ELEV_W:0] w_diff;
    logic [ELEV_W:0]        r_mag;
    logic [SPAN_W-1:0]      r_span1;
    logic [2*ELEV_W+1:0]    r_sq;
    logic [SPAN_W-1:0]      r_span2;
    logic [SPAN_W-1:0]      r_rad;
    logic [SPAN_W/2-1:0]    w_root;

    assign w_diff = {i_z1[ELEV_W-1], i_z1} - {i_z2[ELEV_W-1], i_z2};

    always_ff @(posedge i_clk) begin
        r_mag   <= w_diff[ELEV_W] ? (ELEV_W+1)'(-w_diff) : w_diff;
        r_span1 <= i_span;
        r_sq    <= r_mag * r_mag;
        r_span2 <= r_span1;
        r_rad   <= r_span2 + r_sq;
    end

    wsa_isqrt #(.IN_W(SPAN_W)) u_isqrt (
        .i_clk  (i_clk),
        .i_x    (r_rad),
        .o_root (w_root)
    );

    assign o_half = w_root[HALF_W:1];

endmodule

### src/wsa_tri.sv
// Triangle lane: Heron area of one triangle from three half-edges, Q36.14.
// Depends on wsa_pkg and wsa_isqrt.
module wsa_tri
    import wsa_pkg::*;
(
    input  logic               i_clk,
    input  logic [HALF_W-1:0]  i_a,
    input  logic [HALF_W-1:0]  i_b,
    input  logic [HALF_W-1:0]  i_c,
    output logic [TAREA_W-1:0] o_area
);

    localparam int F_W = HALF_W + 2;
    localparam int P_W = 2 * F_W;
    localparam int T_W = 2 * P_W;

    logic [F_W:0]     w_f0, w_f1, w_f2, w_f3;
    logic [F_W-1:0]   r_f0, r_f1, r_f2, r_f3;
    logic             r_neg1, r_neg2, r_neg3;
    logic [P_W-1:0]   r_p01, r_p23;
    logic [P_W-1:0]   r_ll, r_lh, r_hl, r_hh;
    logic [P_W:0]     w_mid;
    logic [T_W-1:0]   w_prod;
    logic [RADIC_W-1:0] r_rad;

    assign w_f0 = {3'b0, i_a} + {3'b0, i_b} + {3'b0, i_c};
    assign w_f1 = {3'b0, i_b} + {3'b0, i_c} - {3'b0, i_a};
    assign w_f2 = {3'b0, i_a} + {3'b0, i_c} - {3'b0, i_b};
    assign w_f3 = {3'b0, i_a} + {3'b0, i_b} - {3'b0, i_c};

    assign w_mid  = {1'b0, r_lh} + {1'b0, r_hl};
    assign w_prod = {r_hh, {P_W{1'b0}}} + {{(F_W-1){1'b0}}, w_mid, {F_W{1'b0}}}
                  + {{P_W{1'b0}}, r_ll};

    always_ff @(posedge i_clk) begin
        r_f0   <= w_f0[F_W-1:0];
        r_f1   <= w_f1[F_W-1:0];
        r_f2   <= w_f2[F_W-1:0];
        r_f3   <= w_f3[F_W-1:0];
        r_neg1 <= w_f1[F_W] | w_f2[F_W] | w_f3[F_W];
        r_p01  <= r_f0 * r_f1;
        r_p23  <= r_f2 * r_f3;
        r_neg2 <= r_neg1;
        r_ll   <= r_p01[F_W-1:0]   * r_p23[F_W-1:0];
        r_lh   <= r_p01[F_W-1:0]   * r_p23[P_W-1:F_W];
        r_hl   <= r_p01[P_W-1:F_W] * r_p23[F_W-1:0];
        r_hh   <= r_p01[P_W-1:F_W] * r_p23[P_W-1:F_W];
        r_neg3 <= r_neg2;
        r_rad  <= r_neg3 ? '0 : w_prod[T_W-1 -: RADIC_W];
    end

    wsa_isqrt #(.IN_W(RADIC_W)) u_isqrt (
        .i_clk  (i_clk),
        .i_x    (r_rad),
        .o_root (o_area)
    );

endmodule

### src/wsa_merge.sv
// Merge stage: adds the kept triangle areas in a registered tree, then rescales
// by 8 / kept in drop mode, else by one, via a pipelined radix-2 divider. Depends on wsa_pkg.
module wsa_merge
    import wsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_info              i_info,
    input  logic [TAREA_W-1:0] i_area [TRIS],
    output logic               o_done,
    output logic [AREA_W-1:0]  o_area,
    output logic               o_area_valid,
    output logic               o_window_last
);

    typedef struct packed {
        logic vld;
        logic last;
        logic ok;
    } t_res;

    logic [TAREA_W:0]   r_s1 [4];
    logic [TAREA_W+1:0] r_s2 [2];
    logic [SUM_W-1:0]   r_s3;
    logic [CNT_W-1:0]   r_cnt1, r_cnt2, r_cnt3;
    t_info              r_info1, r_info2, r_info3;

    logic [DIV_W-1:0]   w_dividend;
    logic [CNT_W-1:0]   w_divisor;
    t_res               w_res0;

    logic [DIV_W-1:0]   r_w   [1:DIV_W];
    logic [CNT_W-1:0]   r_rem [1:DIV_W-1];
    logic [CNT_W-1:0]   r_dvs [1:DIV_W-1];
    t_res               r_res [1:DIV_W];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r_s1[j] <= (i_info.keep[2*j] ? {1'b0, i_area[2*j]} : '0)
                     + (i_info.keep[2*j+1] ? {1'b0, i_area[2*j+1]} : '0);
        end
        for (int j = 0; j < 2; j++) begin
            r_s2[j] <= {1'b0, r_s1[2*j]} + {1'b0, r_s1[2*j+1]};
        end
        r_s3   <= {1'b0, r_s2[0]} + {1'b0, r_s2[1]};
        r_cnt1 <= CNT_W'($countones(i_info.keep));
        r_cnt2 <= r_cnt1;
        r_cnt3 <= r_cnt2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info1 <= '0;
            r_info2 <= '0;
            r_info3 <= '0;
        end else begin
            r_info1 <= i_info;
            r_info2 <= r_info1;
            r_info3 <= r_info2;
        end
    end

    // Strict mode divides the plain sum by one, so both modes share the divider.
    always_comb begin
        w_res0.vld  = r_info3.vld;
        w_res0.last = r_info3.last;
        if (r_info3.drop) begin
            w_dividend = {r_s3, 3'b000};
            w_divisor  = (r_cnt3 == '0) ? CNT_W'(1) : r_cnt3;
            w_res0.ok  = (r_cnt3 != '0);
        end else begin
            w_dividend = {3'b000, r_s3};
            w_divisor  = CNT_W'(1);
            w_res0.ok  = r_info3.full;
        end
    end

    genvar s;
    for (s = 0; s < DIV_W; s++) begin : g_div
        logic [DIV_W-1:0] w_in;
        logic [CNT_W-1:0] rem_in;
        logic [CNT_W-1:0] dvs_in;
        t_res             res_in;
        logic [CNT_W:0]   rem_sh;
        logic [CNT_W:0]   rem_nx;
        logic             take;

        if (s == 0) begin : g_first
            assign w_in   = w_dividend;
            assign rem_in = '0;
            assign dvs_in = w_divisor;
            assign res_in = w_res0;
        end else begin : g_next
            assign w_in   = r_w[s];
            assign rem_in = r_rem[s];
            assign dvs_in = r_dvs[s];
            assign res_in = r_res[s];
        end

        assign rem_sh = {rem_in, w_in[DIV_W-1]};
        assign take   = (rem_sh >= {1'b0, dvs_in});
        assign rem_nx = take ? (rem_sh - {1'b0, dvs_in}) : rem_sh;

        always_ff @(posedge i_clk) begin
            r_w[s+1] <= {w_in[DIV_W-2:0], take};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_res[s+1] <= '0;
            end else begin
                r_res[s+1] <= res_in;
            end
        end

        if (s < DIV_W - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                r_rem[s+1] <= rem_nx[CNT_W-1:0];
                r_dvs[s+1] <= dvs_in;
            end
        end
    end

    assign o_done        = r_res[DIV_W].vld;
    assign o_area_valid  = r_res[DIV_W].ok;
    assign o_window_last = r_res[DIV_W].last;
    assign o_area        = r_res[DIV_W].ok ? {{(AREA_W-DIV_W){1'b0}}, r_w[DIV_W]} : '0;

endmodule

### sim/window_surface_area_checker.sv
// Checker for the window surface area core: predicts the result of each accepted
// window and compares every result transaction field by field. Depends on wsa_pkg.
`timescale 1ns / 1ps

module window_surface_area_checker
    import wsa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_A_W-1:0]       i_cfg_addr,
    input  logic [SIZE_W-1:0]        i_cfg_wdata,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic signed [ELEV_W-1:0] i_elev [CELLS],
    input  logic [CELLS-1:0]         i_valid_mask,
    input  logic                     i_last_window,
    input  logic                     i_done,
    input  logic [AREA_W-1:0]        i_area,
    input  logic                     i_area_valid,
    input  logic                     i_window_last,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct {
        logic [AREA_W-1:0] area;
        logic              area_valid;
        logic              window_last;
    } t_area_result;

    localparam logic [63:0] AREA_SAT = 64'h7FFF_FFFF_FFFF_FFFF;

    // Edge order: ab bc de ef gh hi, ad dg be eh cf fi, ea ec eg ei.
    localparam int EDGE_A [EDGES] = '{0, 1, 3, 4, 6, 7, 0, 3, 1, 4, 2, 5, 4, 4, 4, 4};
    localparam int EDGE_B [EDGES] = '{1, 2, 4, 5, 7, 8, 3, 6, 4, 7, 5, 8, 0, 2, 6, 8};
    localparam int SIDES [TRIS][3] = '{
        '{12, 0, 8}, '{8, 1, 13}, '{6, 2, 12}, '{13, 10, 3},
        '{2, 7, 14}, '{3, 11, 15}, '{14, 9, 4}, '{9, 15, 5}};
    localparam int CORNERS [TRIS][3] = '{
        '{4, 0, 1}, '{1, 2, 4}, '{0, 3, 4}, '{2, 5, 4},
        '{3, 6, 4}, '{5, 8, 4}, '{6, 7, 4}, '{7, 8, 4}};

    logic [31:0]  size_x, size_y;
    logic         drop_mode;
    t_area_result area_fifo [$];
    int           mismatches;

    function automatic logic [69:0] int_sqrt(input logic [139:0] v);
        logic [69:0]  r;
        logic [69:0]  t;
        logic [139:0] sq;
        r = '0;
        for (int b = 69; b >= 0; b--) begin
            t = r | (70'd1 << b);
            sq = {70'd0, t} * {70'd0, t};
            if (sq <= v) r = t;
        end
        return r;
    endfunction

    function automatic logic [31:0] half_edge_len(input logic [139:0] span2,
                                                  input logic signed [31:0] za,
                                                  input logic signed [31:0] zb);
        logic signed [32:0] d;
        logic [139:0]       m;
        logic [69:0]        r;
        d = 33'(za) - 33'(zb);
        m = d < 0 ? 140'(-d) : 140'(d);
        r = int_sqrt(span2 + m * m);
        return 32'(r >> 1);
    endfunction

    function automatic logic [63:0] heron_area(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c);
        logic signed [35:0] f [4];
        logic [143:0]       p;
        logic [143:0]       q;
        f[0] = $signed({4'd0, a}) + $signed({4'd0, b}) + $signed({4'd0, c});
        f[1] = -$signed({4'd0, a}) + $signed({4'd0, b}) + $signed({4'd0, c});
        f[2] = $signed({4'd0, a}) - $signed({4'd0, b}) + $signed({4'd0, c});
        f[3] = $signed({4'd0, a}) + $signed({4'd0, b}) - $signed({4'd0, c});
        p = 144'd1;
        for (int k = 0; k < 4; k++) begin
            if (f[k] < 0) return 64'd0;
            p = p * 144'(f[k]);
        end
        q = p >> 36;
        return 64'(int_sqrt(q[139:0]));
    endfunction

    function automatic t_area_result window_area(input logic signed [31:0] z [CELLS],
                                                 input logic [CELLS-1:0] mask,
                                                 input logic last);
        logic [139:0] span2 [3];
        logic [31:0]  edge_len [EDGES];
        logic [63:0]  sum;
        logic [63:0]  ta;
        logic [64:0]  s;
        logic [63:0]  scaled;
        int           kept;
        bit           ok;
        t_area_result res;
        span2[0] = {76'd0, size_x} * {76'd0, size_x};
        span2[1] = {76'd0, size_y} * {76'd0, size_y};
        span2[2] = span2[0] + span2[1];
        for (int k = 0; k < EDGES; k++)
            edge_len[k] = half_edge_len(span2[k < 6 ? 0 : (k < 12 ? 1 : 2)],
                                        z[EDGE_A[k]], z[EDGE_B[k]]);
        sum = '0;
        kept = 0;
        for (int t = 0; t < TRIS; t++) begin
            ok = mask[CORNERS[t][0]] && mask[CORNERS[t][1]] && mask[CORNERS[t][2]];
            if (ok) begin
                ta = heron_area(edge_len[SIDES[t][0]], edge_len[SIDES[t][1]],
                                edge_len[SIDES[t][2]]);
                s = {1'b0, sum} + {1'b0, ta};
                sum = s > {1'b0, AREA_SAT} ? AREA_SAT : s[63:0];
                kept++;
            end
        end
        res.area = '0;
        res.area_valid = 1'b0;
        res.window_last = last;
        if (drop_mode) begin
            if (kept > 0) begin
                scaled = sum > (AREA_SAT >> 3) ? AREA_SAT : sum * 8;
                res.area = AREA_W'(scaled / kept);
                res.area_valid = 1'b1;
            end
        end else if (mask == '1) begin
            res.area = AREA_W'(sum);
            res.area_valid = 1'b1;
        end
        return res;
    endfunction

    assign o_pending = area_fifo.size();
    assign o_fail_count = mismatches;

    initial mismatches = 0;

    always @(posedge i_clk) begin
        t_area_result want;
        if (!i_rst_n) begin
            size_x = 32'd65536;
            size_y = 32'd65536;
            drop_mode = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SIZE_X: size_x = i_cfg_wdata;
                    CFG_SIZE_Y: size_y = i_cfg_wdata;
                    CFG_DROP:   drop_mode = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_done) begin
                if (area_fifo.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result transaction at %0t", $time);
                end else begin
                    want = area_fifo.pop_front();
                    if (i_area !== want.area || i_area_valid !== want.area_valid
                            || i_window_last !== want.window_last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch at %0t: area %h/%h valid %b/%b last %b/%b",
                                     $time, want.area, i_area, want.area_valid, i_area_valid,
                                     want.window_last, i_window_last);
                    end
                end
            end
            if (i_start && !i_busy)
                area_fifo.push_back(window_area(i_elev, i_valid_mask, i_last_window));
        end
    end

endmodule

### sim/tb.sv
// Testbench top for window_surface_area_core: clock, reset, configuration phases
// and window stimulus. Depends on wsa_pkg, the core and window_surface_area_checker.
`timescale 1ns / 1ps

module tb;
    import wsa_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_A_W-1:0]       i_cfg_addr = CFG_SIZE_X;
    logic [SIZE_W-1:0]        i_cfg_wdata = '0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [ELEV_W-1:0] elev [CELLS];
    logic [CELLS-1:0]         i_valid_mask = '0;
    logic                     i_last_window = 1'b0;
    logic                     o_done;
    logic [AREA_W-1:0]        o_area;
    logic                     o_area_valid;
    logic                     o_window_last;
    int                       fail_count;
    int                       pending;
    int                       cycles = 0;
    bit                       gaps_on;

    always #6 i_clk = ~i_clk;

    initial for (int k = 0; k < CELLS; k++) elev[k] = '0;

    window_surface_area_core uut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata, .start, .busy,
        .i_elev_a(elev[0]), .i_elev_b(elev[1]), .i_elev_c(elev[2]),
        .i_elev_d(elev[3]), .i_elev_e(elev[4]), .i_elev_f(elev[5]),
        .i_elev_g(elev[6]), .i_elev_h(elev[7]), .i_elev_i(elev[8]),
        .i_valid_mask, .i_last_window, .o_done, .o_area, .o_area_valid, .o_window_last
    );

    window_surface_area_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata, .i_start(start),
        .i_busy(busy), .i_elev(elev), .i_valid_mask, .i_last_window, .i_done(o_done),
        .i_area(o_area), .i_area_valid(o_area_valid), .i_window_last(o_window_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("** window_surface_area_core: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [SIZE_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_addr = addr;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_window(input logic signed [31:0] z [CELLS], input logic [8:0] mask,
                               input logic last);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        repeat (gap) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        elev = z;
        i_valid_mask = mask;
        i_last_window = last;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic directed_windows();
        logic signed [31:0] z [CELLS];
        for (int n = 0; n < 12; n++) begin
            for (int k = 0; k < CELLS; k++)
                case (n % 4)
                    0: z[k] = '0;
                    1: z[k] = (k % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                    2: z[k] = (k == 4) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                    default: z[k] = 32'(k * 32'h0001_8000);
                endcase
            case (n / 4)
                0: send_window(z, 9'h1FF, n[0]);
                1: send_window(z, n[0] ? 9'h000 : 9'h1EF, n[1]);
                default: send_window(z, 9'h1FF ^ (9'd1 << (n % 9)), n[0]);
            endcase
        end
    endtask

    task automatic random_windows(input int count);
        logic signed [31:0] z [CELLS];
        logic signed [31:0] base;
        logic [8:0]         mask;
        int                 style;
        for (int n = 0; n < count; n++) begin
            style = $urandom_range(0, 9);
            base = $urandom;
            for (int k = 0; k < CELLS; k++)
                case (style)
                    0, 1: z[k] = $urandom;
                    2: z[k] = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                    default: z[k] = base + $signed(32'($urandom_range(0, 32'h0008_0000)))
                                    - 32'sh0004_0000;
                endcase
            mask = $urandom_range(0, 9) < 6 ? 9'h1FF : 9'($urandom);
            send_window(z, mask, $urandom_range(0, 15) == 0);
        end
    endtask

    initial begin
        gaps_on = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: ;
                1: begin
                    write_reg(CFG_SIZE_X, 32'd1);
                    write_reg(CFG_SIZE_Y, 32'd1);
                    write_reg(CFG_DROP, 32'd1);
                end
                2: begin
                    write_reg(CFG_SIZE_X, 32'hFFFF_FFFF);
                    write_reg(CFG_SIZE_Y, 32'hFFFF_FFFF);
                    write_reg(CFG_DROP, 32'd0);
                end
                3: write_reg(CFG_DROP, 32'd1);
                default: begin
                    write_reg(CFG_SIZE_X, $urandom_range(1, 32'h0010_0000));
                    write_reg(CFG_SIZE_Y, $urandom_range(0, 3) == 0 ? $urandom
                                                              : $urandom_range(1, 32'h0010_0000));
                    write_reg(CFG_DROP, {31'd0, phase[0]});
                end
            endcase
            if (phase < 2) directed_windows();
            gaps_on = phase % 3 != 0;
            random_windows(180);
            drain();
        end
        repeat (160) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** window_surface_area_core: PASSED **");
        end else begin
            $display("** window_surface_area_core: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
src/wsa_pkg.sv
src/wsa_isqrt.sv
src/wsa_edge.sv
src/wsa_tri.sv
src/wsa_merge.sv
src/window_surface_area_core.sv
sim/window_surface_area_checker.sv
sim/tb.sv
